// ===== rtl/b64d_pkg.sv =====
// Shared types and constants of the base64 stream decoder.
`default_nettype none
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [7:0] BAD_FLAG  = 8'h80;
   localparam logic [7:0] PAD_CODE  = 8'hFE;
   localparam logic [7:0] BAD_CODE  = 8'hFF;
   localparam logic [7:0] PLUS_CODE = 8'h3E;
   localparam logic [7:0] SLASH_CODE = 8'h3F;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Result words buffered ahead of the output; a power of two.
   localparam int RSP_DEPTH = 4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_PAD     = 2'd1,
      STATUS_LENGTH  = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef struct packed {
      logic        item_kind;
      logic        final_item;
      status_type  status_code;
      logic [31:0] error_position;
      logic [31:0] text_length;
      logic [7:0]  data_byte;
   } rsp_item_type;

   // One decoded input word yields up to two result words.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } rsp_push_type;

endpackage
`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Top level of the streaming base64 decoder.
//
// The req_ channel takes one encoded character per word in req_tdata, with
// req_tlast on the final character of a text. The rsp_ channel gives decoded
// bytes (rsp_tuser low) as soon as each one is complete, and after the last
// character one status word (rsp_tuser high, rsp_tlast high) with the status
// code, plus the first bad character's index if invalid or the decoded length if OK.
// A word is accepted in every cycle while the result buffer has room; a
// character passes the input register and then the result buffer before
// its first result word. A closing character that completes a byte gives
// two result words, which leave one per cycle while the receiver is ready.
// When the receiver stalls, results collect in a four-word buffer; once
// fewer than two entries are free, a character held in the input register
// waits and req_tready drops; nothing is lost.
// Reset clears the decoder state and the buffer, and the next character
// starts a new text. After a status word the decoder also starts anew.
`default_nettype none
module base64_stream_decoder #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata,   // [7:0] data_byte, [9:8] status_code,
                                         // [41:10] error_position,
                                         // [73:42] text_length, rest zero
   output logic             rsp_tuser,   // item_kind
   output logic             rsp_tlast    // final_item
);
   import b64d_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_char_ff;
   logic         in_last_ff;
   logic         room;
   logic         fire;
   rsp_push_type push;
   rsp_item_type head;

   assign fire = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   b64d_decode #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_code   (in_char_ff),
      .end_of_text (in_last_ff),
      .push        (push)
   );

   b64d_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (head)
   );

   assign rsp_tdata = {6'd0, head.text_length, head.error_position,
                       head.status_code, head.data_byte};
   assign rsp_tuser = head.item_kind;
   assign rsp_tlast = head.final_item;

endmodule
`default_nettype wire

// ===== rtl/b64d_decode.sv =====
// Character mapping, decoder state and result formation for one word a cycle while fire is high.
`default_nettype none
module b64d_decode #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [7:0]         char_code,
   input  wire logic               end_of_text,
   output b64d_pkg::rsp_push_type  push
);
   import b64d_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   logic [1:0]             group_phase_ff, group_phase_in;
   logic [5:0]             held_sextet_ff, held_sextet_in;
   logic [1:0]             pending_pads_ff, pending_pads_in;
   logic                   pad_overflow_ff, pad_overflow_in;
   logic                   invalid_seen_ff, invalid_seen_in;
   logic [COUNT_WIDTH-1:0] first_bad_index_ff, first_bad_index_in;
   logic [COUNT_WIDTH-1:0] char_index_ff, char_index_in;
   logic [COUNT_WIDTH-1:0] bytes_out_ff, bytes_out_in;

   function automatic logic [7:0] sextet_of(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
      else if (c == 8'h2B) v = PLUS_CODE;
      else if (c == 8'h2F) v = SLASH_CODE;
      else if (c == PAD_CHAR) v = PAD_CODE;
      else v = BAD_CODE;
      return v;
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
      return (x == COUNT_MAX) ? x : x + COUNT_ONE;
   endfunction

   function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] x);
      logic [63:0] wide;
      wide = 64'(x);
      return (wide[63:32] != 32'd0) ? 32'hFFFF_FFFF : wide[31:0];
   endfunction

   logic [7:0]   sextet;
   logic         is_pad;
   logic         emit;
   logic [7:0]   byte_val;
   rsp_item_type data_item;
   rsp_item_type status_item;

   always_comb begin
      sextet = sextet_of(char_code);
      is_pad = (sextet == PAD_CODE);
      emit = 1'b0;
      byte_val = 8'd0;

      group_phase_in = group_phase_ff;
      held_sextet_in = held_sextet_ff;
      pending_pads_in = pending_pads_ff;
      pad_overflow_in = pad_overflow_ff;
      invalid_seen_in = invalid_seen_ff;
      first_bad_index_in = first_bad_index_ff;
      bytes_out_in = bytes_out_ff;

      if (is_pad) begin
         // The start of a pad run is kept in case data follows it.
         if (pending_pads_ff == 2'd0 && !pad_overflow_ff && !invalid_seen_ff) begin
            first_bad_index_in = char_index_ff;
         end
         if (pending_pads_ff == 2'd2) begin
            pad_overflow_in = 1'b1;
         end
         pending_pads_in = pending_pads_ff + 2'd1;
      end else begin
         // Data after padding makes the run's first pad the bad character.
         if (pending_pads_ff != 2'd0 || pad_overflow_ff) begin
            invalid_seen_in = 1'b1;
         end
         group_phase_in = group_phase_ff + pending_pads_ff;
         pending_pads_in = 2'd0;
         pad_overflow_in = 1'b0;
         if ((sextet & BAD_FLAG) != 8'd0) begin
            if (!invalid_seen_in) begin
               invalid_seen_in = 1'b1;
               first_bad_index_in = char_index_ff;
            end
         end else if (!invalid_seen_in) begin
            case (group_phase_in)
               2'd1:    byte_val = {held_sextet_ff[5:0], sextet[5:4]};
               2'd2:    byte_val = {held_sextet_ff[3:0], sextet[5:2]};
               2'd3:    byte_val = {held_sextet_ff[1:0], sextet[5:0]};
               default: byte_val = 8'd0;
            endcase
            emit = (group_phase_in != 2'd0);
            held_sextet_in = sextet[5:0];
            if (emit) begin
               bytes_out_in = sat_inc(bytes_out_ff);
            end
         end
         group_phase_in = group_phase_in + 2'd1;
      end
      char_index_in = sat_inc(char_index_ff);

      data_item = '0;
      data_item.item_kind = KIND_DATA;
      data_item.data_byte = byte_val;

      status_item = '0;
      status_item.item_kind = KIND_STATUS;
      status_item.final_item = 1'b1;
      if (is_pad && pad_overflow_in) begin
         status_item.status_code = STATUS_PAD;
      end else if (group_phase_in == 2'd1) begin
         status_item.status_code = STATUS_LENGTH;
      end else if (invalid_seen_in) begin
         status_item.status_code = STATUS_INVALID;
         status_item.error_position = sat32(first_bad_index_in);
      end else begin
         status_item.status_code = STATUS_OK;
         status_item.text_length = sat32(bytes_out_in);
      end

      push.count = 2'({1'b0, emit} + {1'b0, end_of_text});
      push.first = emit ? data_item : status_item;
      push.second = status_item;
      if (!fire) begin
         push.count = 2'd0;
      end

      // The status word closes the text and the next word starts a new one.
      if (end_of_text) begin
         group_phase_in = 2'd0;
         held_sextet_in = 6'd0;
         pending_pads_in = 2'd0;
         pad_overflow_in = 1'b0;
         invalid_seen_in = 1'b0;
         first_bad_index_in = '0;
         char_index_in = '0;
         bytes_out_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_phase_ff <= 2'd0;
         held_sextet_ff <= 6'd0;
         pending_pads_ff <= 2'd0;
         pad_overflow_ff <= 1'b0;
         invalid_seen_ff <= 1'b0;
         first_bad_index_ff <= '0;
         char_index_ff <= '0;
         bytes_out_ff <= '0;
      end else if (fire) begin
         group_phase_ff <= group_phase_in;
         held_sextet_ff <= held_sextet_in;
         pending_pads_ff <= pending_pads_in;
         pad_overflow_ff <= pad_overflow_in;
         invalid_seen_ff <= invalid_seen_in;
         first_bad_index_ff <= first_bad_index_in;
         char_index_ff <= char_index_in;
         bytes_out_ff <= bytes_out_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/b64d_rsp_fifo.sv =====
// Small result buffer taking up to two words a cycle and giving one while out_ready is high.
`default_nettype none
module b64d_rsp_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire b64d_pkg::rsp_push_type push,
   output logic                       room,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output b64d_pkg::rsp_item_type     out_item
);
   import b64d_pkg::*;

   localparam int PTR_WIDTH = $clog2(RSP_DEPTH);
   localparam int CNT_WIDTH = $clog2(RSP_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] ROOM_LIMIT = CNT_WIDTH'(RSP_DEPTH - 2);

   rsp_item_type           entries_ff [RSP_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [PTR_WIDTH-1:0]   wr_next;
   logic                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item = entries_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   // Room for a full pair of result words.
   assign room = (count_ff <= ROOM_LIMIT);
   assign wr_next = wr_ptr_ff + PTR_WIDTH'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_WIDTH'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_WIDTH'(pop);
      count_in = count_ff + CNT_WIDTH'(push.count) - CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the base64 stream decoder with random stalls on both channels.
module tb;
   import b64d_pkg::*;

   localparam int RANDOM_CHARS = 1000;
   localparam int QUIET_TAIL   = 120;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic [7:0] code;
      logic       final_char;
   } char_word_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] char_code
   logic        req_tlast = 1'b0;    // end_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;           // [7:0] data_byte, [9:8] status_code,
                                     // [41:10] error_position,
                                     // [73:42] text_length, rest zero
   logic        rsp_tuser;           // item_kind
   logic        rsp_tlast;           // final_item

   char_word_t   pending_chars[$];
   logic [7:0]   text_chars[$];
   rsp_item_type decoded_words[$];

   // Decoder state as the bench sees it.
   logic [1:0]  group_phase;
   logic [5:0]  held_sextet;
   logic [1:0]  pad_run;
   logic        pad_overflow;
   logic        invalid_seen;
   logic [31:0] first_bad_index;
   logic [31:0] char_index;
   logic [31:0] bytes_out;

   int req_gap;
   int rsp_gap;
   int stall_cycles = 0;
   int mismatches = 0;
   int texts_queued = 0;
   int chars_sent = 0;
   int data_words = 0;
   int status_words[4] = '{0, 0, 0, 0};

   base64_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] sextet_code(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return c - "A";
      if (c >= "a" && c <= "z") return c - "a" + 8'd26;
      if (c >= "0" && c <= "9") return c - "0" + 8'd52;
      if (c == "+") return PLUS_CODE;
      if (c == "/") return SLASH_CODE;
      if (c == PAD_CHAR) return PAD_CODE;
      return BAD_CODE;
   endfunction

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      if (s < 26) return "A" + s;
      if (s < 52) return "a" + (s - 6'd26);
      if (s < 62) return "0" + (s - 6'd52);
      if (s == 62) return "+";
      return "/";
   endfunction

   task automatic clear_decoder();
      group_phase     = '0;
      held_sextet     = '0;
      pad_run         = '0;
      pad_overflow    = 1'b0;
      invalid_seen    = 1'b0;
      first_bad_index = '0;
      char_index      = '0;
      bytes_out       = '0;
   endtask

   task automatic push_word(input logic kind, input logic [7:0] data, input status_type code,
                            input logic [31:0] pos, input logic [31:0] len);
      rsp_item_type w;
      w.item_kind      = kind;
      w.final_item     = kind;
      w.status_code    = code;
      w.error_position = pos;
      w.text_length    = len;
      w.data_byte      = data;
      decoded_words.push_back(w);
   endtask

   // Advances the decoder by one character and queues the words it yields.
   task automatic decode_char(input logic [7:0] c, input logic final_char);
      logic [7:0] v;
      logic [7:0] data;
      status_type code;
      logic [31:0] pos;
      logic [31:0] len;
      v = sextet_code(c);
      if (v == PAD_CODE) begin
         if (pad_run == 0 && !pad_overflow && !invalid_seen) first_bad_index = char_index;
         if (pad_run == 2) pad_overflow = 1'b1;
         pad_run = pad_run + 2'd1;
      end else begin
         // Data after a run of padding makes the run's first '=' invalid.
         if (pad_run != 0 || pad_overflow) invalid_seen = 1'b1;
         group_phase  = group_phase + pad_run;
         pad_run      = '0;
         pad_overflow = 1'b0;
         if ((v & BAD_FLAG) != 0) begin
            if (!invalid_seen) begin
               invalid_seen    = 1'b1;
               first_bad_index = char_index;
            end
         end else if (!invalid_seen) begin
            case (group_phase)
               2'd1: data = {held_sextet, v[5:4]};
               2'd2: data = {held_sextet[3:0], v[5:2]};
               2'd3: data = {held_sextet[1:0], v[5:0]};
               default: data = '0;
            endcase
            if (group_phase != 0) begin
               push_word(KIND_DATA, data, STATUS_OK, '0, '0);
               if (bytes_out != '1) bytes_out++;
            end
            held_sextet = v[5:0];
         end
         group_phase = group_phase + 2'd1;
      end
      if (char_index != '1) char_index++;
      if (final_char) begin
         pos = '0;
         len = '0;
         if (v == PAD_CODE && pad_overflow) code = STATUS_PAD;
         else if (group_phase == 2'd1) code = STATUS_LENGTH;
         else if (invalid_seen) begin
            code = STATUS_INVALID;
            pos  = first_bad_index;
         end else begin
            code = STATUS_OK;
            len  = bytes_out;
         end
         push_word(KIND_STATUS, 8'h00, code, pos, len);
         clear_decoder();
      end
   endtask

   task automatic commit_text();
      char_word_t w;
      foreach (text_chars[i]) begin
         w.code       = text_chars[i];
         w.final_char = (i == text_chars.size() - 1);
         pending_chars.push_back(w);
      end
      text_chars.delete();
      texts_queued++;
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) text_chars.push_back(s[i]);
      commit_text();
   endtask

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : driver
      char_word_t next_char;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap = 0;
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            chars_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 12);
               req_tvalid <= 1'b0;
            end else begin
               next_char = pending_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_char.code;
               req_tlast  <= next_char.final_char;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tuser) status_words[rsp_tdata[9:8]]++;
            else data_words++;
            if (decoded_words.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h/%b/%b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatches++;
            end else begin
               want = decoded_words.pop_front();
               compare_field("item_kind", want.item_kind, rsp_tuser);
               compare_field("final_item", want.final_item, rsp_tlast);
               compare_field("data_byte", want.data_byte, rsp_tdata[7:0]);
               compare_field("status_code", want.status_code, rsp_tdata[9:8]);
               compare_field("error_position", want.error_position, rsp_tdata[41:10]);
               compare_field("text_length", want.text_length, rsp_tdata[73:42]);
               compare_field("tdata fill", '0, rsp_tdata[79:74]);
            end
         end
         if (rsp_gap != 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (pending_chars.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Cycles in a row in which neither channel moved a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin : main
      int random_chars;
      int shape;
      int n;
      logic [23:0] bits;
      bit padded;
      random_chars = 0;

      // Directed texts: full quads, lone pad, lone data character, top of the
      // alphabet, too much padding, padding inside data, and illegal bytes.
      add_string("QUJD");
      add_string("=");
      add_string("Z");
      add_string("z9+/");
      add_string("AA===");
      add_string("A=B");
      text_chars = '{"A", "B", 8'h80, 8'hFF};
      commit_text();

      // Mostly well-formed encodings of random bytes, some of them damaged.
      while (random_chars < RANDOM_CHARS) begin
         shape = $urandom_range(0, 9);
         if (shape == 9) begin
            n = $urandom_range(1, 8);
            repeat (n) text_chars.push_back(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(1, 12);
            padded = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < n; i += 3) begin
               bits = 24'($urandom);
               text_chars.push_back(sextet_char(bits[23:18]));
               text_chars.push_back(sextet_char(bits[17:12]));
               if (n - i >= 2) text_chars.push_back(sextet_char(bits[11:6]));
               else if (padded) text_chars.push_back(PAD_CHAR);
               if (n - i >= 3) text_chars.push_back(sextet_char(bits[5:0]));
               else if (padded) text_chars.push_back(PAD_CHAR);
            end
            case (shape)
               6: text_chars[$urandom_range(0, text_chars.size() - 1)] =
                     8'($urandom_range(0, 255));
               7: repeat ($urandom_range(1, 3)) text_chars.push_back(PAD_CHAR);
               8: text_chars.delete($urandom_range(0, text_chars.size() - 1));
               default: ;
            endcase
         end
         random_chars += text_chars.size();
         commit_text();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while ((pending_chars.size() != 0 || req_tvalid || decoded_words.size() != 0)
             && stall_cycles < STALL_LIMIT)
         @(negedge clock);
      if (stall_cycles < STALL_LIMIT) repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Decoded %0d characters in %0d texts, %0d data bytes checked.",
               chars_sent, texts_queued, data_words);
      $display("Status words: ok %0d, padding %0d, length %0d, invalid %0d.",
               status_words[0], status_words[1], status_words[2], status_words[3]);
      if (stall_cycles >= STALL_LIMIT || mismatches != 0)
         $display("base64_stream_decoder test failed");
      else
         $display("base64_stream_decoder test passed");
      $finish;
   end
endmodule
